FILE: rtl/ttb_pkg.sv
// shared types and constants for the triangle tangent basis core
`timescale 1ns / 1ps

package ttb_pkg;

  localparam int unsigned CoordW    = 16;
  localparam int unsigned DeltaW    = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DeltaW;
  localparam int unsigned AccW      = ProdW + 1;
  localparam int unsigned MagW      = AccW - 1;
  localparam int unsigned FracShift = 20;
  localparam int unsigned DivW      = MagW + FracShift;
  localparam int unsigned DivCntW   = $clog2(DivW);
  localparam int unsigned CompW     = 32;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumComps  = 2 * NumAxes;

  localparam logic [CompW-1:0] SatMax = {1'b0, {(CompW-1){1'b1}}};
  localparam logic [CompW-1:0] SatMin = {1'b1, {(CompW-1){1'b0}}};

  typedef enum logic [1:0] {
    CORNER_FIRST,
    CORNER_SECOND,
    CORNER_THIRD
  } corner_e;

  // quantity being formed: the determinant, then the six components
  typedef enum logic [2:0] {
    QTY_DET,
    QTY_TAN_X,
    QTY_TAN_Y,
    QTY_TAN_Z,
    QTY_BIT_X,
    QTY_BIT_Y,
    QTY_BIT_Z
  } qty_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_DET,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic    corner_load;
    corner_e corner;
    qty_e    qty;
    logic    mul_term;
    logic    acc_load;
    logic    acc_sub;
    logic    det_load;
    logic    div_init;
    logic    div_step;
    logic    res_load;
    logic    out_load;
    logic    out_degen;
  } ttb_cmd_t;

  typedef struct packed {
    logic det_zero;
  } ttb_stat_t;

endpackage

FILE: rtl/ttb_datapath.sv
// datapath: corner store, shared multiplier and accumulator, radix-2 divider
`timescale 1ns / 1ps

module ttb_datapath
  import ttb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic signed [CoordW-1:0] tex_u_i,
  input  logic signed [CoordW-1:0] tex_v_i,
  input  ttb_cmd_t                 cmd_i,
  output ttb_stat_t                stat_o,
  output logic [CompW-1:0]         tangent_o   [NumAxes],
  output logic [CompW-1:0]         bitangent_o [NumAxes],
  output logic                     degenerate_o
);

  logic signed [CoordW-1:0] p0_q [NumAxes];
  logic signed [CoordW-1:0] p1_q [NumAxes];
  logic signed [CoordW-1:0] u0_q, v0_q, u1_q, v1_q;
  logic signed [CoordW-1:0] pin [NumAxes];

  logic signed [DeltaW-1:0] e1_q [NumAxes];
  logic signed [DeltaW-1:0] e2_q [NumAxes];
  logic signed [DeltaW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  logic signed [DeltaW-1:0] op_a, op_b;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]          acc_abs;
  logic [1:0]               axis;

  logic [MagW-1:0]  det_mag_q, rem_q, rem_d;
  logic             det_neg_q, num_neg_q;
  logic [DivW-1:0]  dvd_q;
  logic [CompW-1:0] quo_q, sat;
  logic             ovf_q, quo_bit, quo_big;
  logic [MagW:0]    trial;
  logic [2:0]       res_idx;
  logic [CompW-1:0] res_q [NumComps];
  logic [CompW-1:0] tan_q [NumAxes];
  logic [CompW-1:0] bit_q [NumAxes];
  logic             degen_q;

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  // corner store; the third corner is turned into edges and deltas at once
  always_ff @(posedge clk_i) begin
    if (cmd_i.corner_load) begin
      case (cmd_i.corner)
        CORNER_FIRST: begin
          for (int k = 0; k < NumAxes; k++) p0_q[k] <= pin[k];
          u0_q <= tex_u_i;
          v0_q <= tex_v_i;
        end
        CORNER_SECOND: begin
          for (int k = 0; k < NumAxes; k++) p1_q[k] <= pin[k];
          u1_q <= tex_u_i;
          v1_q <= tex_v_i;
        end
        default: begin
          for (int k = 0; k < NumAxes; k++) begin
            e1_q[k] <= {p1_q[k][CoordW-1], p1_q[k]} - {p0_q[k][CoordW-1], p0_q[k]};
            e2_q[k] <= {pin[k][CoordW-1], pin[k]} - {p0_q[k][CoordW-1], p0_q[k]};
          end
          du1_q <= {u1_q[CoordW-1], u1_q} - {u0_q[CoordW-1], u0_q};
          dv1_q <= {v1_q[CoordW-1], v1_q} - {v0_q[CoordW-1], v0_q};
          du2_q <= {tex_u_i[CoordW-1], tex_u_i} - {u0_q[CoordW-1], u0_q};
          dv2_q <= {tex_v_i[CoordW-1], tex_v_i} - {v0_q[CoordW-1], v0_q};
        end
      endcase
    end
  end

  // every quantity has the form a*b - c*d; term selects the product
  always_comb begin
    op_a = '0;
    op_b = '0;
    axis = '0;
    case (cmd_i.qty)
      QTY_DET: begin
        op_a = cmd_i.mul_term ? du2_q : du1_q;
        op_b = cmd_i.mul_term ? dv1_q : dv2_q;
      end
      QTY_TAN_X, QTY_TAN_Y, QTY_TAN_Z: begin
        axis = 2'(3'(cmd_i.qty) - 3'(QTY_TAN_X));
        op_a = cmd_i.mul_term ? dv1_q : dv2_q;
        op_b = cmd_i.mul_term ? e2_q[axis] : e1_q[axis];
      end
      QTY_BIT_X, QTY_BIT_Y, QTY_BIT_Z: begin
        axis = 2'(3'(cmd_i.qty) - 3'(QTY_BIT_X));
        op_a = cmd_i.mul_term ? du2_q : du1_q;
        op_b = cmd_i.mul_term ? e1_q[axis] : e2_q[axis];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = {prod_q[ProdW-1], prod_q};
    end else if (cmd_i.acc_sub) begin
      acc_d = acc_q - {prod_q[ProdW-1], prod_q};
    end
  end

  assign acc_abs         = acc_q[AccW-1] ? (~acc_q + 1'b1) : acc_q;
  assign stat_o.det_zero = (acc_q == '0);

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    acc_q  <= acc_d;
    if (cmd_i.det_load) begin
      det_mag_q <= acc_abs[MagW-1:0];
      det_neg_q <= acc_q[AccW-1];
    end
  end

  // restoring division of |num| * 2^20 by |det|, one quotient bit per step
  assign trial   = {rem_q, dvd_q[DivW-1]};
  assign quo_bit = (trial >= {1'b0, det_mag_q});
  assign rem_d   = quo_bit ? MagW'(trial - {1'b0, det_mag_q}) : trial[MagW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q     <= {acc_abs[MagW-1:0], {FracShift{1'b0}}};
      rem_q     <= '0;
      quo_q     <= '0;
      ovf_q     <= 1'b0;
      num_neg_q <= acc_q[AccW-1];
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[CompW-2:0], quo_bit};
      ovf_q <= ovf_q | quo_q[CompW-1];
    end
  end

  // quotient at or above 2^31 saturates
  assign quo_big = ovf_q | quo_q[CompW-1];

  always_comb begin
    if (num_neg_q ^ det_neg_q) begin
      sat = quo_big ? SatMin : (~quo_q + 1'b1);
    end else begin
      sat = quo_big ? SatMax : quo_q;
    end
  end

  assign res_idx = 3'(cmd_i.qty) - 3'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q[res_idx] <= sat;
    end
    if (cmd_i.out_load) begin
      for (int k = 0; k < NumAxes; k++) begin
        tan_q[k] <= cmd_i.out_degen ? '0 : res_q[k];
        bit_q[k] <= cmd_i.out_degen ? '0 : res_q[NumAxes + k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degen_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      degen_q <= cmd_i.out_degen;
    end
  end

  assign tangent_o    = tan_q;
  assign bitangent_o  = bit_q;
  assign degenerate_o = degen_q;

endmodule

FILE: rtl/ttb_ctrl.sv
// controller: corner count, step sequencing and output valid
`timescale 1ns / 1ps

module ttb_ctrl
  import ttb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  ttb_stat_t stat_i,
  output ttb_cmd_t  cmd_o
);

  state_e             state_q, state_d;
  corner_e            count_q, count_d;
  qty_e               qty_q, qty_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               degen_q, degen_d;
  logic               out_valid_q, out_valid_d;
  logic               out_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CORNER_FIRST;
      qty_q       <= QTY_DET;
      cnt_q       <= '0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      qty_q       <= qty_d;
      cnt_q       <= cnt_d;
      degen_q     <= degen_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_slot = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    qty_d       = qty_q;
    cnt_d       = cnt_q;
    degen_d     = degen_q;
    out_valid_d = out_valid_q && !m_ready_i;
    s_ready_o   = 1'b0;
    cmd_o           = '0;
    cmd_o.corner    = count_q;
    cmd_o.qty       = qty_q;
    cmd_o.out_degen = degen_q;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.corner_load = 1'b1;
          case (count_q)
            CORNER_FIRST:  count_d = CORNER_SECOND;
            CORNER_SECOND: count_d = CORNER_THIRD;
            default: begin
              count_d = CORNER_FIRST;
              qty_d   = QTY_DET;
              state_d = ST_MUL_A;
            end
          endcase
        end
      end
      ST_MUL_A: begin
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_term = 1'b1;
        cmd_o.acc_load = 1'b1;
        state_d        = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd_o.acc_sub = 1'b1;
        state_d       = (qty_q == QTY_DET) ? ST_DET : ST_DIV_INIT;
      end
      ST_DET: begin
        cmd_o.det_load = 1'b1;
        degen_d        = stat_i.det_zero;
        if (stat_i.det_zero) begin
          state_d = ST_EMIT;
        end else begin
          qty_d   = QTY_TAN_X;
          state_d = ST_MUL_A;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = DivCntW'(DivW - 1);
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.res_load = 1'b1;
        if (qty_q == QTY_BIT_Z) begin
          state_d = ST_EMIT;
        end else begin
          qty_d   = qty_e'(3'(qty_q) + 3'd1);
          state_d = ST_MUL_A;
        end
      end
      ST_EMIT: begin
        if (out_slot) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i))
    else $error("result loaded over a pending result");

  a_busy_after_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o && count_q == CORNER_THIRD) |=> !s_ready_o)
    else $error("request taken while a triangle is in work");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_FIN))
    else $error("divider did not finish on its last step");

  a_last_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && qty_q == QTY_BIT_Z) |=> (state_q == ST_EMIT))
    else $error("last component did not lead to the result");
`endif

endmodule

FILE: rtl/triangle_tangent_basis_core.sv
// top level of the per-triangle tangent and bitangent core
// Takes triangle corners as requests, three per triangle, and returns one
// result per triangle holding the tangent and bitangent in signed Q16.16,
// each trunc(num * 2^20 / det) saturated to 32 bits, with a degenerate flag
// and zero vectors when the uv determinant is zero. The first and second
// corner of a triangle are taken even while the previous result still
// waits on the output register. The third corner starts the work and the
// input stays not ready until the result moves to the output register.
// MUL_A, MUL_B, MUL_C and DET form the determinant; a degenerate triangle
// then goes straight to EMIT. Else each of the six components passes
// MUL_A, MUL_B and MUL_C on the shared 17x17 multiplier, a setup state and
// 54 steps of the single radix-2 divider and a state to saturate and store,
// and EMIT moves the result to the output register once it is free.
`timescale 1ns / 1ps

module triangle_tangent_basis_core
  import ttb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  // corner requests
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [79:0]    s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  // triangle results
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [191:0]   m_axis_tdata,   // tangent_x/y/z, bitangent_x/y/z
  output logic           m_axis_tuser    // degenerate
);

  ttb_cmd_t         cmd;
  ttb_stat_t        stat;
  logic [CompW-1:0] tangent   [NumAxes];
  logic [CompW-1:0] bitangent [NumAxes];

  // controller owns corner count, step order and result valid
  ttb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // datapath unpacks the request fields from the lowest bits up
  ttb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pos_x_i      (s_axis_tdata[15:0]),
    .pos_y_i      (s_axis_tdata[31:16]),
    .pos_z_i      (s_axis_tdata[47:32]),
    .tex_u_i      (s_axis_tdata[63:48]),
    .tex_v_i      (s_axis_tdata[79:64]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .tangent_o    (tangent),
    .bitangent_o  (bitangent),
    .degenerate_o (m_axis_tuser)
  );

  // tangent x in the lowest word, bitangent z in the highest
  assign m_axis_tdata = {bitangent[2], bitangent[1], bitangent[0],
                         tangent[2], tangent[1], tangent[0]};

endmodule

FILE: tb/sv/ttb_basis_checker.sv
// checker that predicts and compares triangle tangent basis results
`timescale 1ns / 1ps

module ttb_basis_checker
  import ttb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [79:0]  s_tdata_i,    // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [191:0] m_tdata_i,    // tangent_x/y/z, bitangent_x/y/z
  input  logic         m_tuser_i,    // degenerate
  output int           fail_count_o,
  output int           pending_o,
  output int           results_o,
  output int           degen_o,
  output int           sat_o
);

  typedef struct packed {
    logic                           degen;
    logic [NumComps-1:0][CompW-1:0] comp;
  } basis_t;

  basis_t  basis_q[$];
  corner_e next_corner;
  longint  first_pos[NumAxes];
  longint  second_pos[NumAxes];
  longint  first_uv[2];
  longint  second_uv[2];
  string   comp_name[NumComps] = '{"tangent_x", "tangent_y", "tangent_z",
                                   "bitangent_x", "bitangent_y", "bitangent_z"};

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // trunc(num * 2^20 / det) with saturation to signed 32 bits
  function automatic logic [CompW-1:0] scale_q16(input longint num, input longint det,
                                                 output bit sat);
    logic [63:0] mag_num;
    logic [63:0] mag_det;
    logic [63:0] quo;
    mag_num = (num < 0) ? -num : num;
    mag_det = (det < 0) ? -det : det;
    quo = (mag_num << FracShift) / mag_det;
    sat = 1'b0;
    if ((num < 0) != (det < 0)) begin
      if (quo >= 64'h8000_0000) begin
        sat = 1'b1;
        return SatMin;
      end
      return -quo[CompW-1:0];
    end
    if (quo > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return SatMax;
    end
    return quo[CompW-1:0];
  endfunction

  // tangent and bitangent of the held corners plus the third one
  function automatic basis_t predict_basis(input longint pos[NumAxes], input longint uv[2]);
    basis_t b;
    longint e1, e2, du1, dv1, du2, dv2, det;
    bit     sat;
    b   = '0;
    du1 = second_uv[0] - first_uv[0];
    dv1 = second_uv[1] - first_uv[1];
    du2 = uv[0] - first_uv[0];
    dv2 = uv[1] - first_uv[1];
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) begin
      b.degen = 1'b1;
      degen_o++;
      return b;
    end
    for (int k = 0; k < NumAxes; k++) begin
      e1 = second_pos[k] - first_pos[k];
      e2 = pos[k] - first_pos[k];
      b.comp[k] = scale_q16(dv2 * e1 - dv1 * e2, det, sat);
      if (sat) sat_o++;
      b.comp[NumAxes + k] = scale_q16(du1 * e2 - du2 * e1, det, sat);
      if (sat) sat_o++;
    end
    return b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    basis_t want;
    longint pos[NumAxes];
    longint uv[2];
    if (!rst_ni) begin
      next_corner  = CORNER_FIRST;
      first_pos    = '{0, 0, 0};
      second_pos   = '{0, 0, 0};
      first_uv     = '{0, 0};
      second_uv    = '{0, 0};
      basis_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      degen_o      = 0;
      sat_o        = 0;
    end else begin
      // results first: the queue only holds older triangles
      if (m_tvalid_i && m_tready_i) begin
        if (basis_q.size() == 0) begin
          report_mismatch("triangle result with no triangle pending");
        end else begin
          want = basis_q.pop_front();
          for (int k = 0; k < NumComps; k++) begin
            if (m_tdata_i[k*CompW +: CompW] !== want.comp[k]) begin
              report_mismatch($sformatf("%s got %h want %h", comp_name[k],
                                        m_tdata_i[k*CompW +: CompW], want.comp[k]));
            end
          end
          if (m_tuser_i !== want.degen) begin
            report_mismatch($sformatf("degenerate got %b want %b", m_tuser_i, want.degen));
          end
        end
        results_o++;
      end
      if (s_tvalid_i && s_tready_i) begin
        for (int k = 0; k < NumAxes; k++) begin
          pos[k] = longint'($signed(s_tdata_i[k*CoordW +: CoordW]));
        end
        uv[0] = longint'($signed(s_tdata_i[3*CoordW +: CoordW]));
        uv[1] = longint'($signed(s_tdata_i[4*CoordW +: CoordW]));
        case (next_corner)
          CORNER_FIRST: begin
            first_pos   = pos;
            first_uv    = uv;
            next_corner = CORNER_SECOND;
          end
          CORNER_SECOND: begin
            second_pos  = pos;
            second_uv   = uv;
            next_corner = CORNER_THIRD;
          end
          default: begin
            basis_q.push_back(predict_basis(pos, uv));
            next_corner = CORNER_FIRST;
          end
        endcase
      end
      pending_o = basis_q.size();
    end
  end

endmodule

FILE: tb/sv/triangle_tangent_basis_core_tb.sv
// stimulus, clocking and verdict for the triangle tangent basis core
`timescale 1ns / 1ps

module triangle_tangent_basis_core_tb;

  // random triangles after the directed ones
  localparam int RandTriangles = 167;
  // idle-free tail of the run starts at this random triangle
  localparam int CalmFrom      = 147;
  // long output hold-off, started once this many corners went in
  localparam int HoldAfter     = 150;
  localparam int HoldCycles    = 2000;
  // a third corner keeps the block busy until its result is moved out
  localparam int DrainCycles   = 400;
  localparam int CycleLimit    = 500_000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata  = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;         // tangent_x/y/z, bitangent_x/y/z
  logic         m_axis_tuser;         // degenerate

  int corners_sent = 0;
  bit calm         = 1'b0;
  int cycles       = 0;
  int fail_count;
  int pending;
  int results;
  int degens;
  int sats;

  triangle_tangent_basis_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // watches both channels, predicts each triangle and compares
  ttb_basis_checker basis_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .degen_o     (degens),
    .sat_o       (sats)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pack one corner request, pos_x in the lowest bits
  function automatic logic [79:0] pack_corner(input int px, input int py, input int pz,
                                              input int u, input int v);
    return {v[15:0], u[15:0], pz[15:0], py[15:0], px[15:0]};
  endfunction

  // uniform value in -half .. half-1
  function automatic int rand_span(input int half);
    return int'($urandom_range(0, 2 * half - 1)) - half;
  endfunction

  // random triangle: full range, tiny uv spread, degenerate uv or moderate values
  function automatic logic [2:0][79:0] random_triangle();
    logic [2:0][79:0] c;
    int pos[3][3];
    int uv[3][2];
    int shape;
    shape = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) pos[i][k] = rand_span(32768);
      for (int j = 0; j < 2; j++) uv[i][j] = rand_span(32768);
    end
    if (shape >= 35 && shape < 55) begin
      // tiny determinant, quotients mostly saturate
      for (int j = 0; j < 2; j++) begin
        uv[0][j] = rand_span(1024);
        uv[1][j] = uv[0][j] + rand_span(4);
        uv[2][j] = uv[0][j] + rand_span(4);
      end
    end else if (shape >= 55 && shape < 65) begin
      // third corner repeats a uv, determinant is zero
      uv[2] = $urandom_range(0, 1) ? uv[0] : uv[1];
    end else if (shape >= 65) begin
      // moderate values, quotients mostly in range
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) pos[i][k] = rand_span(2048);
        for (int j = 0; j < 2; j++) uv[i][j] = rand_span(4096);
      end
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = pack_corner(pos[i][0], pos[i][1], pos[i][2], uv[i][0], uv[i][1]);
    end
    return c;
  endfunction

  // offer one corner request until accepted, at times after a random gap
  task automatic put_corner(input logic [79:0] c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    corners_sent++;
  endtask

  task automatic put_triangle(input logic [79:0] c0, input logic [79:0] c1,
                              input logic [79:0] c2);
    put_corner(c0);
    put_corner(c1);
    put_corner(c2);
  endtask

  initial begin : stimulus
    logic [2:0][79:0] tri_rand;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero, degenerate
    put_triangle(pack_corner(0, 0, 0, 0, 0), pack_corner(0, 0, 0, 0, 0),
                 pack_corner(0, 0, 0, 0, 0));
    // unit edges and unit uv, identity basis
    put_triangle(pack_corner(0, 0, 0, 0, 0), pack_corner(256, 0, 0, 4096, 0),
                 pack_corner(0, 256, 0, 0, 4096));
    // extreme positions, det of one: positive saturation and zero numerators
    put_triangle(pack_corner(-32768, -32768, -32768, 0, 0),
                 pack_corner(32767, -32768, 0, 1, 0),
                 pack_corner(0, 32767, -32768, 0, 1));
    // same with swapped uv, det of minus one: negative numerators, positive saturation
    put_triangle(pack_corner(-32768, -32768, -32768, 0, 0),
                 pack_corner(32767, -32768, 0, 0, 1),
                 pack_corner(0, 32767, -32768, 1, 0));
    // extreme uv, largest positive det
    put_triangle(pack_corner(32767, 32767, 32767, -32768, -32768),
                 pack_corner(-32768, 0, 32767, 32767, -32768),
                 pack_corner(0, -32768, -1, -32768, 32767));
    // extreme uv, largest negative det
    put_triangle(pack_corner(0, 0, 0, 32767, 32767),
                 pack_corner(1234, -567, 89, 32767, -32768),
                 pack_corner(-4000, 300, -20, -32768, 32767));
    // coincident positions, all numerators zero
    put_triangle(pack_corner(100, -200, 300, 0, 0), pack_corner(100, -200, 300, 4096, 0),
                 pack_corner(100, -200, 300, 0, 4096));
    // collinear uv with real edges, degenerate
    put_triangle(pack_corner(10, 20, 30, 0, 0), pack_corner(-500, 60, 7, 100, 200),
                 pack_corner(800, -90, 1, 300, 600));

    for (int n = 0; n < RandTriangles; n++) begin
      if (n >= CalmFrom) calm = 1'b1;
      tri_rand = random_triangle();
      put_triangle(tri_rand[0], tri_rand[1], tri_rand[2]);
    end
    s_axis_tvalid <= 1'b0;

    // drain: every triangle answered, then let the block settle
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d corners, %0d triangle results (%0d degenerate, %0d saturated comps)",
             corners_sent, results, degens, sats);
    $display("output held off once for %0d cycles with corners still offered", HoldCycles);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off, none in the tail
  initial begin : receiver
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && corners_sent >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d triangles still pending", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

endmodule
